// ===== sv/text_glyph_framebuffer_renderer_defines.svh =====
// Assertion helpers for the checker file
`ifndef TEXT_GLYPH_FRAMEBUFFER_RENDERER_DEFINES_SVH
`define TEXT_GLYPH_FRAMEBUFFER_RENDERER_DEFINES_SVH

// ante holds at an edge, so cons holds at the next edge
`define TGFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tgfr assertion failed");

// ante holds at an edge, so cons holds at that same edge
`define TGFR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tgfr assertion failed");

`endif

// ===== sv/tgfr_pkg.sv =====
package tgfr_pkg;

    localparam int IDX_W       = 15;
    localparam int CHAR_W      = 8;
    localparam int COORD_W     = 8;
    localparam int COL_W       = 9;
    localparam int COLOR_W     = 8;
    localparam int FONT_W      = 32;
    localparam int GLYPH_IDX_W = 6;
    localparam int GLYPH_N     = 5;
    localparam int GLYPH_ADV   = 6;
    localparam int IY_W        = 3;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_CURSOR = 2'd1;
    localparam logic [1:0] FUNC_DRAW   = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    localparam logic [COL_W-1:0]       COL_MAX        = 9'h1FF;
    localparam logic [COLOR_W-1:0]     COLOR_RESET    = 8'hFF;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_SPACE    = 6'h00;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_BANG     = 6'h1B;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_QUESTION = 6'h1C;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_HASH     = 6'h1D;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_COMMA    = 6'h1E;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_DOT      = 6'h1F;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_COLON    = 6'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_DIV,
        ST_READ,
        ST_DONE
    } state_t;

    function automatic logic [GLYPH_IDX_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
        case (c) inside
            [8'h61:8'h7A]: glyph_of = GLYPH_IDX_W'(c - 8'h60);
            [8'h41:8'h5A]: glyph_of = GLYPH_IDX_W'(c - 8'h40);
            [8'h30:8'h39]: glyph_of = GLYPH_IDX_W'(c - 8'h0F);
            8'h21:         glyph_of = GLYPH_BANG;
            8'h3F:         glyph_of = GLYPH_QUESTION;
            8'h23:         glyph_of = GLYPH_HASH;
            8'h2C:         glyph_of = GLYPH_COMMA;
            8'h2E:         glyph_of = GLYPH_DOT;
            8'h3A:         glyph_of = GLYPH_COLON;
            8'h20:         glyph_of = GLYPH_SPACE;
            default:       glyph_of = GLYPH_QUESTION;
        endcase
    endfunction

    // 5x5 cell, MSB first, row-major: bit 31-(ix+5*iy) is pixel (ix, iy)
    function automatic logic [FONT_W-1:0] font_word(input logic [GLYPH_IDX_W-1:0] g);
        case (g)
            6'd0:    font_word = 32'h00000000;
            6'd1:    font_word = 32'h747F1880;
            6'd2:    font_word = 32'hE4BD1F00;
            6'd3:    font_word = 32'h7C210780;
            6'd4:    font_word = 32'hF4631F00;
            6'd5:    font_word = 32'hFC3F0F80;
            6'd6:    font_word = 32'hFC3F0800;
            6'd7:    font_word = 32'h7C2F1780;
            6'd8:    font_word = 32'h8C7F1880;
            6'd9:    font_word = 32'h71084700;
            6'd10:   font_word = 32'h71094400;
            6'd11:   font_word = 32'h8DB14980;
            6'd12:   font_word = 32'h84210F80;
            6'd13:   font_word = 32'hDD6B1880;
            6'd14:   font_word = 32'h8E6B3880;
            6'd15:   font_word = 32'h74631700;
            6'd16:   font_word = 32'hF47D0800;
            6'd17:   font_word = 32'h64A56780;
            6'd18:   font_word = 32'hF47D8B80;
            6'd19:   font_word = 32'h7C1C1F00;
            6'd20:   font_word = 32'hF9084200;
            6'd21:   font_word = 32'h8C631700;
            6'd22:   font_word = 32'h8C54A200;
            6'd23:   font_word = 32'h8C6B5D80;
            6'd24:   font_word = 32'hDA88AD80;
            6'd25:   font_word = 32'h8A884200;
            6'd26:   font_word = 32'hF8888F80;
            6'd27:   font_word = 32'h21080200;
            6'd28:   font_word = 32'h744C0200;
            6'd29:   font_word = 32'h57D5F500;
            6'd30:   font_word = 32'h00004400;
            6'd31:   font_word = 32'h00000400;
            6'd32:   font_word = 32'h01004000;
            6'd33:   font_word = 32'h746B1700;
            6'd34:   font_word = 32'h23084700;
            6'd35:   font_word = 32'h744C8F80;
            6'd36:   font_word = 32'h744D1700;
            6'd37:   font_word = 32'h32A5F100;
            6'd38:   font_word = 32'hF43C1700;
            6'd39:   font_word = 32'h741D1700;
            6'd40:   font_word = 32'hFC444200;
            6'd41:   font_word = 32'h745D1700;
            6'd42:   font_word = 32'h745C1700;
            default: font_word = 32'h744C0200;
        endcase
    endfunction

endpackage

// ===== sv/text_glyph_framebuffer_renderer.sv =====
// Clear and set cursor: the block stays idle and ready for the next command.
// Draw: busy after the beat; one glyph row read per cycle, each written back in the next cycle.
// Read pixel: row by reciprocal multiply, then column from the remainder and row read, then the
//   result register; out of range skips to a blank result; a held result stalls the next one.
// Reset: cursor to 0, color to 0xFF, per-row valid flags cleared so every row reads blank;
//   clear does the same to the flags.
module text_glyph_framebuffer_renderer #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [tgfr_pkg::COORD_W-1:0]        pos_x,
    input  logic [tgfr_pkg::COORD_W-1:0]        pos_y,
    input  logic [tgfr_pkg::CHAR_W-1:0]         char_code,
    input  logic [tgfr_pkg::IDX_W-1:0]          pixel_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tgfr_pkg::COLOR_W-1:0]        pixel_value,
    input  logic                                cfg_wr_en,
    input  logic [tgfr_pkg::COLOR_W-1:0]        cfg_wr_data
);

    localparam int AW         = $clog2(FRAME_HEIGHT);
    localparam int XW         = $clog2(FRAME_WIDTH);
    localparam int FRAME_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int SIZE_W     = $clog2(FRAME_SIZE) + 1;
    localparam int DW         = (SIZE_W > tgfr_pkg::IDX_W + 1) ? SIZE_W : tgfr_pkg::IDX_W + 1;
    // ceil(2^RECIP_SH / FRAME_WIDTH) gives an exact quotient for every index
    localparam int RECIP_SH   = tgfr_pkg::IDX_W + XW;
    localparam int MUL_W      = tgfr_pkg::IDX_W + 1;
    localparam int PROD_W     = tgfr_pkg::IDX_W + MUL_W;
    localparam logic [MUL_W-1:0] RECIP_M =
        MUL_W'((2 ** RECIP_SH + FRAME_WIDTH - 1) / FRAME_WIDTH);

    tgfr_pkg::state_t state_reg, state_next;

    logic [tgfr_pkg::IY_W-1:0]    iy_reg, iy_next;
    logic [AW-1:0]                q_reg, q_next;
    logic [tgfr_pkg::IDX_W-1:0]   rem_reg, rem_next;
    logic [tgfr_pkg::COL_W-1:0]   cursor_col_reg, cursor_col_next;
    logic [tgfr_pkg::COORD_W-1:0] cursor_row_reg, cursor_row_next;
    logic [tgfr_pkg::FONT_W-1:0]  glyph_reg, glyph_next;
    logic                         oor_reg, oor_next;
    logic                         out_valid_reg, out_valid_next;
    logic [tgfr_pkg::COLOR_W-1:0] pixel_value_reg, pixel_value_next;
    logic [tgfr_pkg::COLOR_W-1:0] pixel_color_reg;
    logic [FRAME_HEIGHT-1:0]      row_valid_reg;
    logic                         row_ok_reg;
    logic [AW-1:0]                wr_addr_reg;
    logic [FRAME_WIDTH-1:0]       rd_row_reg;
    logic                         rd_valid_reg;

    logic [FRAME_WIDTH-1:0]       frame_mem [FRAME_HEIGHT];

    logic                         clear_c;
    logic                         rd_en_c;
    logic                         wr_en_c;
    logic                         in_ready_c;
    logic [AW-1:0]                rd_addr_c;
    logic [tgfr_pkg::COL_W:0]     row_sum_c;
    logic                         row_ok_c;
    logic [FRAME_WIDTH-1:0]       mask_c;
    logic [FRAME_WIDTH-1:0]       gdata_c;
    logic [FRAME_WIDTH-1:0]       wr_data_c;
    logic [tgfr_pkg::GLYPH_N-1:0] gl_row_c;
    logic [PROD_W-1:0]            prod_c;
    logic [tgfr_pkg::IDX_W-1:0]   row_base_c;
    logic [tgfr_pkg::COL_W:0]     col_sum_c;
    logic                         lit_c;

    // draw datapath
    always_comb
    begin
        for (int ix = 0; ix < tgfr_pkg::GLYPH_N; ix++)
        begin
            gl_row_c[ix] = glyph_reg[tgfr_pkg::FONT_W-1-ix];
        end
        // shifting past the frame edge drops the clipped pixels
        mask_c    = {{(FRAME_WIDTH-tgfr_pkg::GLYPH_N){1'b0}}, {tgfr_pkg::GLYPH_N{1'b1}}}
                    << cursor_col_reg;
        gdata_c   = {{(FRAME_WIDTH-tgfr_pkg::GLYPH_N){1'b0}}, gl_row_c} << cursor_col_reg;
        wr_data_c = ((rd_valid_reg ? rd_row_reg : '0) & ~mask_c) | gdata_c;
        row_sum_c = {2'b00, cursor_row_reg} + (tgfr_pkg::COL_W+1)'(iy_reg);
        row_ok_c  = row_sum_c < (tgfr_pkg::COL_W+1)'(FRAME_HEIGHT);
        col_sum_c = {1'b0, cursor_col_reg} + (tgfr_pkg::COL_W+1)'(tgfr_pkg::GLYPH_ADV);
    end

    // index split: row from a reciprocal multiply, column from the remainder
    always_comb
    begin
        prod_c     = PROD_W'(rem_reg) * PROD_W'(RECIP_M);
        row_base_c = tgfr_pkg::IDX_W'(q_reg) * tgfr_pkg::IDX_W'(FRAME_WIDTH);
        lit_c      = !oor_reg && rd_valid_reg && rd_row_reg[rem_reg[XW-1:0]];
    end

    always_comb
    begin
        state_next       = state_reg;
        iy_next          = iy_reg;
        q_next           = q_reg;
        rem_next         = rem_reg;
        cursor_col_next  = cursor_col_reg;
        cursor_row_next  = cursor_row_reg;
        glyph_next       = glyph_reg;
        oor_next         = oor_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pixel_value_next = pixel_value_reg;
        clear_c          = 1'b0;
        rd_en_c          = 1'b0;
        wr_en_c          = 1'b0;
        in_ready_c       = 1'b0;
        rd_addr_c        = (state_reg == tgfr_pkg::ST_DRAW) ? row_sum_c[AW-1:0] : q_reg;

        case (state_reg)
            tgfr_pkg::ST_IDLE:
            begin
                in_ready_c = 1'b1;
                if (in_valid)
                begin
                    case (func)
                        tgfr_pkg::FUNC_CLEAR:
                        begin
                            clear_c = 1'b1;
                        end
                        tgfr_pkg::FUNC_CURSOR:
                        begin
                            cursor_col_next = tgfr_pkg::COL_W'(pos_x);
                            cursor_row_next = pos_y;
                        end
                        tgfr_pkg::FUNC_DRAW:
                        begin
                            glyph_next = tgfr_pkg::font_word(tgfr_pkg::glyph_of(char_code));
                            iy_next    = '0;
                            state_next = tgfr_pkg::ST_DRAW;
                        end
                        default:
                        begin
                            rem_next = pixel_index;
                            q_next   = '0;
                            if (DW'(pixel_index) >= DW'(FRAME_SIZE))
                            begin
                                oor_next   = 1'b1;
                                state_next = tgfr_pkg::ST_DONE;
                            end
                            else
                            begin
                                oor_next   = 1'b0;
                                state_next = tgfr_pkg::ST_DIV;
                            end
                        end
                    endcase
                end
            end
            tgfr_pkg::ST_DRAW:
            begin
                rd_en_c = iy_reg < tgfr_pkg::IY_W'(tgfr_pkg::GLYPH_N);
                if (iy_reg != '0)
                begin
                    wr_en_c    = row_ok_reg;
                    glyph_next = glyph_reg << tgfr_pkg::GLYPH_N;
                end
                if (iy_reg == tgfr_pkg::IY_W'(tgfr_pkg::GLYPH_N))
                begin
                    cursor_col_next = col_sum_c[tgfr_pkg::COL_W] ? tgfr_pkg::COL_MAX
                                                                 : col_sum_c[tgfr_pkg::COL_W-1:0];
                    state_next      = tgfr_pkg::ST_IDLE;
                end
                else
                begin
                    iy_next = iy_reg + 1'b1;
                end
            end
            tgfr_pkg::ST_DIV:
            begin
                q_next     = prod_c[RECIP_SH +: AW];
                state_next = tgfr_pkg::ST_READ;
            end
            tgfr_pkg::ST_READ:
            begin
                rd_en_c    = 1'b1;
                rem_next   = rem_reg - row_base_c;
                state_next = tgfr_pkg::ST_DONE;
            end
            tgfr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    pixel_value_next = lit_c ? pixel_color_reg : '0;
                    state_next       = tgfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tgfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tgfr_pkg::ST_IDLE;
            iy_reg          <= '0;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            oor_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            pixel_color_reg <= tgfr_pkg::COLOR_RESET;
            row_valid_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            iy_reg         <= iy_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            oor_reg        <= oor_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                pixel_color_reg <= cfg_wr_data;
            end
            if (clear_c)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en_c)
            begin
                row_valid_reg[wr_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg           <= q_next;
        rem_reg         <= rem_next;
        glyph_reg       <= glyph_next;
        pixel_value_reg <= pixel_value_next;
        if (rd_en_c)
        begin
            row_ok_reg  <= row_ok_c;
            wr_addr_reg <= rd_addr_c;
        end
    end

    // framebuffer rows: one write and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en_c)
        begin
            frame_mem[wr_addr_reg] <= wr_data_c;
        end
        if (rd_en_c)
        begin
            rd_row_reg   <= frame_mem[rd_addr_c];
            rd_valid_reg <= row_valid_reg[rd_addr_c];
        end
    end

    assign in_ready    = in_ready_c;
    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;

endmodule

// ===== sv/tgfr_checker.sv =====
`include "text_glyph_framebuffer_renderer_defines.svh"

module tgfr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [1:0]                   func,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tgfr_pkg::COLOR_W-1:0] pixel_value
);

    logic in_beat;
    logic short_op;

    assign in_beat  = in_valid && in_ready;
    assign short_op = (func == tgfr_pkg::FUNC_CLEAR) || (func == tgfr_pkg::FUNC_CURSOR);

    `TGFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_value))
    `TGFR_ASSERT_NEXT(a_short_op_ready, clk, rst_n, in_beat && short_op, in_ready)
    `TGFR_ASSERT_NEXT(a_long_op_busy, clk, rst_n, in_beat && !short_op, !in_ready)
    `TGFR_ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind text_glyph_framebuffer_renderer tgfr_checker u_tgfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_value(pixel_value)
);

// ===== tb/sv/text_glyph_framebuffer_renderer_tb.sv =====
`timescale 1ns / 100ps

module text_glyph_framebuffer_renderer_tb;

    localparam int FRAME_W       = 160;
    localparam int FRAME_H       = 128;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int SEGMENTS      = 6;
    localparam int SETTLE_CYCLES = 32;

    // color written at the start of each random segment, segment 0 in the top byte
    localparam logic [8*SEGMENTS-1:0] SEG_COLORS = {
        8'h00, 8'h5A, 8'hA5, 8'hFF, 8'h80, 8'h01
    };

    // glyph 0 first; glyph g sits at FONT_ROM[FONT_W*(42-g) +: FONT_W]
    localparam logic [43*tgfr_pkg::FONT_W-1:0] FONT_ROM = {
        32'h00000000, 32'h747F1880, 32'hE4BD1F00, 32'h7C210780, 32'hF4631F00,
        32'hFC3F0F80, 32'hFC3F0800, 32'h7C2F1780, 32'h8C7F1880, 32'h71084700,
        32'h71094400, 32'h8DB14980, 32'h84210F80, 32'hDD6B1880, 32'h8E6B3880,
        32'h74631700, 32'hF47D0800, 32'h64A56780, 32'hF47D8B80, 32'h7C1C1F00,
        32'hF9084200, 32'h8C631700, 32'h8C54A200, 32'h8C6B5D80, 32'hDA88AD80,
        32'h8A884200, 32'hF8888F80, 32'h21080200, 32'h744C0200, 32'h57D5F500,
        32'h00004400, 32'h00000400, 32'h01004000, 32'h746B1700, 32'h23084700,
        32'h744C8F80, 32'h744D1700, 32'h32A5F100, 32'hF43C1700, 32'h741D1700,
        32'hFC444200, 32'h745D1700, 32'h745C1700
    };

    typedef struct packed {
        logic [1:0]                   op;
        logic [tgfr_pkg::COORD_W-1:0] col;
        logic [tgfr_pkg::COORD_W-1:0] row;
        logic [tgfr_pkg::CHAR_W-1:0]  ch;
        logic [tgfr_pkg::IDX_W-1:0]   idx;
        logic                         typed;
        logic [tgfr_pkg::COLOR_W-1:0] val;
    } render_row_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic [1:0]                   func        = tgfr_pkg::FUNC_CLEAR;
    logic [tgfr_pkg::COORD_W-1:0] pos_x       = '0;
    logic [tgfr_pkg::COORD_W-1:0] pos_y       = '0;
    logic [tgfr_pkg::CHAR_W-1:0]  char_code   = '0;
    logic [tgfr_pkg::IDX_W-1:0]   pixel_index = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic [tgfr_pkg::COLOR_W-1:0] pixel_value;
    logic                         cfg_wr_en   = 1'b0;
    logic [tgfr_pkg::COLOR_W-1:0] cfg_wr_data = '0;

    // shadow copy of the frame, cursor and color
    bit                           lit_map [0:FRAME_H-1][0:FRAME_W-1];
    logic [tgfr_pkg::COL_W-1:0]   cursor_col_m;
    logic [tgfr_pkg::COORD_W-1:0] cursor_row_m;
    logic [tgfr_pkg::COLOR_W-1:0] color_m;

    logic [tgfr_pkg::COLOR_W-1:0] pending_pixels [$];
    logic [tgfr_pkg::COLOR_W-1:0] want_pixel;
    render_row_t                  dir_rows [$];

    int send_idle_pct = 38;
    int recv_idle_pct = 81;
    int mismatches    = 0;
    int items_sent    = 0;
    int reads_checked = 0;
    int lit_reads     = 0;
    int op_count [4];

    text_glyph_framebuffer_renderer #(
        .FRAME_WIDTH (FRAME_W),
        .FRAME_HEIGHT(FRAME_H)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .char_code  (char_code),
        .pixel_index(pixel_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_value(pixel_value),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int glyph_code(input logic [tgfr_pkg::CHAR_W-1:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
            return int'(c) - 8'h61 + 1;
        if (c >= 8'h41 && c <= 8'h5A)
            return int'(c) - 8'h41 + 1;
        // digits follow right after the colon cell
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 8'h30 + int'(tgfr_pkg::GLYPH_COLON) + 1;
        case (c)
            8'h21:   return int'(tgfr_pkg::GLYPH_BANG);
            8'h3F:   return int'(tgfr_pkg::GLYPH_QUESTION);
            8'h23:   return int'(tgfr_pkg::GLYPH_HASH);
            8'h2C:   return int'(tgfr_pkg::GLYPH_COMMA);
            8'h2E:   return int'(tgfr_pkg::GLYPH_DOT);
            8'h3A:   return int'(tgfr_pkg::GLYPH_COLON);
            8'h20:   return int'(tgfr_pkg::GLYPH_SPACE);
            default: return int'(tgfr_pkg::GLYPH_QUESTION);
        endcase
    endfunction

    function automatic void apply_render_op(
        input  logic [1:0]                   op,
        input  logic [tgfr_pkg::COORD_W-1:0] x,
        input  logic [tgfr_pkg::COORD_W-1:0] y,
        input  logic [tgfr_pkg::CHAR_W-1:0]  ch,
        input  logic [tgfr_pkg::IDX_W-1:0]   idx,
        output bit                           has_px,
        output logic [tgfr_pkg::COLOR_W-1:0] px_val
    );
        logic [tgfr_pkg::FONT_W-1:0] glyph_bits;
        int px, py, next_col;
        has_px = 1'b0;
        px_val = '0;
        case (op)
            tgfr_pkg::FUNC_CLEAR:
            begin
                for (int r = 0; r < FRAME_H; r++)
                    for (int c = 0; c < FRAME_W; c++)
                        lit_map[r][c] = 1'b0;
            end
            tgfr_pkg::FUNC_CURSOR:
            begin
                cursor_col_m = {1'b0, x};
                cursor_row_m = y;
            end
            tgfr_pkg::FUNC_DRAW:
            begin
                glyph_bits = FONT_ROM[tgfr_pkg::FONT_W*(42-glyph_code(ch)) +: tgfr_pkg::FONT_W];
                for (int iy = 0; iy < tgfr_pkg::GLYPH_N; iy++)
                    for (int ix = 0; ix < tgfr_pkg::GLYPH_N; ix++)
                    begin
                        px = int'(cursor_col_m) + ix;
                        py = int'(cursor_row_m) + iy;
                        // whole cell is written: lit and unlit pixels alike
                        if (px < FRAME_W && py < FRAME_H)
                            lit_map[py][px] =
                                glyph_bits[tgfr_pkg::FONT_W-1-(ix+tgfr_pkg::GLYPH_N*iy)];
                    end
                next_col = int'(cursor_col_m) + tgfr_pkg::GLYPH_ADV;
                cursor_col_m = (next_col > int'(tgfr_pkg::COL_MAX)) ? tgfr_pkg::COL_MAX
                                                                     : tgfr_pkg::COL_W'(next_col);
            end
            default:
            begin
                has_px = 1'b1;
                if (int'(idx) < FRAME_W*FRAME_H && lit_map[idx/FRAME_W][idx%FRAME_W])
                    px_val = color_m;
            end
        endcase
    endfunction

    function automatic render_row_t mk_row(
        input logic [1:0]                   op,
        input logic [tgfr_pkg::COORD_W-1:0] x,
        input logic [tgfr_pkg::COORD_W-1:0] y,
        input logic [tgfr_pkg::CHAR_W-1:0]  ch,
        input logic [tgfr_pkg::IDX_W-1:0]   idx,
        input logic                         typed,
        input logic [tgfr_pkg::COLOR_W-1:0] val
    );
        render_row_t r;
        r.op    = op;
        r.col   = x;
        r.row   = y;
        r.ch    = ch;
        r.idx   = idx;
        r.typed = typed;
        r.val   = val;
        return r;
    endfunction

    function automatic logic [tgfr_pkg::CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 5))
            0:       return tgfr_pkg::CHAR_W'(8'h41 + $urandom_range(0, 25));
            1:       return tgfr_pkg::CHAR_W'(8'h61 + $urandom_range(0, 25));
            2:       return tgfr_pkg::CHAR_W'(8'h30 + $urandom_range(0, 9));
            3:
            begin
                case ($urandom_range(0, 6))
                    0:       return 8'h21;
                    1:       return 8'h3F;
                    2:       return 8'h23;
                    3:       return 8'h2C;
                    4:       return 8'h2E;
                    5:       return 8'h3A;
                    default: return 8'h20;
                endcase
            end
            default: return tgfr_pkg::CHAR_W'($urandom);
        endcase
    endfunction

    // called in the step right after a rising edge; returns in the step of acceptance
    task automatic send_op(
        input logic [1:0]                   op,
        input logic [tgfr_pkg::COORD_W-1:0] x,
        input logic [tgfr_pkg::COORD_W-1:0] y,
        input logic [tgfr_pkg::CHAR_W-1:0]  ch,
        input logic [tgfr_pkg::IDX_W-1:0]   idx,
        input logic                         typed,
        input logic [tgfr_pkg::COLOR_W-1:0] typed_val
    );
        bit                           has_px;
        logic [tgfr_pkg::COLOR_W-1:0] px_val;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        pos_x       <= x;
        pos_y       <= y;
        char_code   <= ch;
        pixel_index <= idx;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        apply_render_op(op, x, y, ch, idx, has_px, px_val);
        if (has_px)
            pending_pixels.push_back(typed ? typed_val : px_val);
        op_count[op]++;
        items_sent++;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        // a draw may still be writing back rows
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_color(input logic [tgfr_pkg::COLOR_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        color_m = v;
    endtask

    task automatic random_burst();
        int kind, x, y, n, m, cx, span;
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            // a line of text: cursor, a run of characters with some reads mixed in, then reads over the run
            if ($urandom_range(0, 1) == 0)
            begin
                x = $urandom_range(0, 20);
                y = $urandom_range(0, 20);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                x = $urandom_range(0, 255);
                y = $urandom_range(0, 255);
            end
            else
            begin
                x = $urandom_range(0, FRAME_W - 1);
                y = $urandom_range(0, FRAME_H - 1);
            end
            send_op(tgfr_pkg::FUNC_CURSOR, tgfr_pkg::COORD_W'(x), tgfr_pkg::COORD_W'(y),
                    tgfr_pkg::CHAR_W'($urandom), tgfr_pkg::IDX_W'($urandom), 1'b0, '0);
            // long runs push the cursor into saturation
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 10);
            for (int k = 0; k < n; k++)
            begin
                cx = x + tgfr_pkg::GLYPH_ADV * k;
                send_op(tgfr_pkg::FUNC_DRAW, tgfr_pkg::COORD_W'($urandom),
                        tgfr_pkg::COORD_W'($urandom), pick_char(),
                        tgfr_pkg::IDX_W'($urandom), 1'b0, '0);
                if ($urandom_range(0, 4) == 0)
                    send_op(tgfr_pkg::FUNC_READ, tgfr_pkg::COORD_W'($urandom),
                            tgfr_pkg::COORD_W'($urandom), tgfr_pkg::CHAR_W'($urandom),
                            tgfr_pkg::IDX_W'((y + $urandom_range(0, 4)) * FRAME_W + cx
                                             + $urandom_range(0, 4)), 1'b0, '0);
            end
            span = (tgfr_pkg::GLYPH_ADV * n < 60) ? tgfr_pkg::GLYPH_ADV * n : 60;
            m = $urandom_range(1, 6);
            for (int k = 0; k < m; k++)
                send_op(tgfr_pkg::FUNC_READ, tgfr_pkg::COORD_W'($urandom),
                        tgfr_pkg::COORD_W'($urandom), tgfr_pkg::CHAR_W'($urandom),
                        tgfr_pkg::IDX_W'((y + $urandom_range(0, 5)) * FRAME_W + x
                                         + $urandom_range(0, span)), 1'b0, '0);
        end
        else if (kind < 95)
        begin
            kind = $urandom_range(0, 3);
            if (kind == int'(tgfr_pkg::FUNC_CLEAR) && $urandom_range(0, 3) != 0)
                kind = int'(tgfr_pkg::FUNC_READ);
            send_op(2'(kind), tgfr_pkg::COORD_W'($urandom), tgfr_pkg::COORD_W'($urandom),
                    tgfr_pkg::CHAR_W'($urandom), tgfr_pkg::IDX_W'($urandom), 1'b0, '0);
        end
        else
        begin
            send_op(tgfr_pkg::FUNC_CLEAR, tgfr_pkg::COORD_W'($urandom),
                    tgfr_pkg::COORD_W'($urandom), tgfr_pkg::CHAR_W'($urandom),
                    tgfr_pkg::IDX_W'($urandom), 1'b0, '0);
            send_op(tgfr_pkg::FUNC_READ, tgfr_pkg::COORD_W'($urandom),
                    tgfr_pkg::COORD_W'($urandom), tgfr_pkg::CHAR_W'($urandom),
                    tgfr_pkg::IDX_W'($urandom_range(0, FRAME_W*FRAME_H - 1)), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: pixel beat with nothing expected, actual %02h", $time,
                         pixel_value);
                mismatches++;
            end
            else
            begin
                want_pixel = pending_pixels.pop_front();
                if (pixel_value !== want_pixel)
                begin
                    $display("%0t: pixel_value expected %02h actual %02h", $time,
                             want_pixel, pixel_value);
                    mismatches++;
                end
                reads_checked++;
                if (want_pixel != 0)
                    lit_reads++;
            end
        end
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        #6_000_000;
        $display("text_glyph_framebuffer_renderer verification failed");
        $finish;
    end

    initial
    begin
        int seg_end;
        for (int r = 0; r < FRAME_H; r++)
            for (int c = 0; c < FRAME_W; c++)
                lit_map[r][c] = 1'b0;
        cursor_col_m = '0;
        cursor_row_m = '0;
        color_m      = tgfr_pkg::COLOR_RESET;
        foreach (op_count[i])
            op_count[i] = 0;

        // reads after reset, extremes of the index, a glyph at the origin, every
        // character class, clipping at the far corner, a fully clipped draw, clear
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_READ,
                                  8'd0,   8'd0,   8'h00, 15'd0,     1, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_READ,
                                  8'd0,   8'd0,   8'h00, 15'd20479, 1, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_READ,
                                  8'hFF,  8'hFF,  8'hFF, 15'h7FFF,  1, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_CURSOR,
                                  8'd0,   8'd0,   8'h00, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h41, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_READ,
                                  8'd0,   8'd0,   8'h00, 15'd1,     1, 8'hFF));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_READ,
                                  8'd0,   8'd0,   8'h00, 15'd0,     1, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h7A, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h30, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h39, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h21, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h3F, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h23, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h2C, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h2E, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h3A, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h20, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'hFF, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_CURSOR,
                                  8'd157, 8'd125, 8'h00, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h4D, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_READ,
                                  8'd0,   8'd0,   8'h00, 15'd20479, 0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_READ,
                                  8'd0,   8'd0,   8'h00, 15'd20157, 1, 8'hFF));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_CURSOR,
                                  8'hFF,  8'hFF,  8'h00, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_DRAW,
                                  8'd0,   8'd0,   8'h00, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_CLEAR,
                                  8'd0,   8'd0,   8'h00, 15'd0,     0, 8'h00));
        dir_rows.push_back(mk_row(tgfr_pkg::FUNC_READ,
                                  8'd0,   8'd0,   8'h00, 15'd20157, 1, 8'h00));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_op(dir_rows[k].op, dir_rows[k].col, dir_rows[k].row, dir_rows[k].ch,
                    dir_rows[k].idx, dir_rows[k].typed, dir_rows[k].val);
        drain_and_settle();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 81 : 0;
            recv_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 38 : 0;
            set_color(SEG_COLORS[8*(SEGMENTS-1-seg) +: 8]);
            seg_end = items_sent + RANDOM_ITEMS / SEGMENTS;
            while (items_sent < seg_end)
                random_burst();
            drain_and_settle();
        end

        $display("ran %0d ops: %0d draws, %0d cursor moves, %0d clears, %0d pixel reads",
                 items_sent, op_count[tgfr_pkg::FUNC_DRAW], op_count[tgfr_pkg::FUNC_CURSOR],
                 op_count[tgfr_pkg::FUNC_CLEAR], op_count[tgfr_pkg::FUNC_READ]);
        $display("%0d pixel beats checked (%0d lit) over %0d colors and three stall profiles",
                 reads_checked, lit_reads, SEGMENTS + 1);
        if (mismatches == 0)
            $display("text_glyph_framebuffer_renderer verification clean");
        else
            $display("text_glyph_framebuffer_renderer verification failed");
        $finish;
    end

endmodule
